[sv/qti_pkg.sv]
// shared constants and types of the quadrilinear table interpolator
package qti_pkg;

	localparam int unsigned POINTS = 8;
	localparam int unsigned IDX_W = $clog2(POINTS);
	localparam int unsigned AXES = 4;
	localparam int unsigned GRID_AW = IDX_W + 2;
	localparam int unsigned TBL_AW = 4 * IDX_W;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned WT_W = 17;
	localparam int unsigned CNT_W = 4;
	localparam logic [WT_W-1:0] ONE_WEIGHT = WT_W'(65536);
	localparam logic [CNT_W-1:0] MIN_POINTS = CNT_W'(2);
	localparam logic [CNT_W-1:0] MAX_POINTS = CNT_W'(POINTS);

	typedef enum logic [1:0] {
		OP_GRID  = 2'd0,
		OP_TABLE = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef struct packed {
		logic        start;
		logic [31:0] num;
		logic [31:0] step;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] quo;
	} div_rsp_t;

endpackage

[sv/quadrilinear_table_interpolator_unit.sv]
// top level of the quadrilinear table interpolator
// s_* channel: one transfer per item. s_tuser is the operation: grid point
// write, table entry write or query. Writes finish in the transfer cycle and
// give no result; a query gives one result on the m_* channel.
// A query scans each axis grid from the grid ram, one point per cycle, then
// computes the cell weight with the divider when the point is inside
// a cell. It then reads the 16 corners from the table ram in turn
// and folds them through one multiplier. An axis that needs no division
// skips the divider, and an out of range axis ends the query early.
// Writes are taken one per cycle while no query is in flight.
// s_tready is high only while no query is in flight; the next item may be
// taken while a result still waits in the output register.
// When m_tready is low the result holds in the output register and a
// finished query waits for it to drain.
// Reset clears control state and sets all point counts to eight; the grid
// and table rams are not cleared and must be written before use.
// cfg_we writes point count cfg_addr (axis zero to three) from cfg_data.
module quadrilinear_table_interpolator_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// axis, write_index, write_value, coord_zero..coord_three, zero pad
	input  logic [175:0] s_tdata,
	// operation
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// interpolated
	output logic [31:0]  m_tdata,
	// out_of_range
	output logic         m_tuser,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_addr,
	input  logic [3:0]   cfg_data
);
	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_SCAN   = 9'b000000010,
		ST_DECIDE = 9'b000000100,
		ST_DIV    = 9'b000001000,
		ST_FETCH  = 9'b000010000,
		ST_CAPT   = 9'b000100000,
		ST_CHAIN  = 9'b001000000,
		ST_ADD    = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

	localparam int unsigned IW = qti_pkg::IDX_W;
	localparam int unsigned CW = qti_pkg::CNT_W;
	localparam int unsigned WW = qti_pkg::WT_W;

	state_t state_q;
	logic [CW-1:0] pts_q [qti_pkg::AXES];
	logic [31:0] coord_q [qti_pkg::AXES];
	logic [1:0] axis_q;
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] didx_q;
	logic dv_q;
	logic found_q;
	logic [IW-1:0] fc_q;
	logic [31:0] prev_q, lo_q, hi_q, g0_q, g1_q, glast_q;
	logic [IW-1:0] cell_q [qti_pkg::AXES];
	logic [WW-1:0] wt_q [qti_pkg::AXES];
	logic oor_q;
	logic [3:0] corner_q;
	logic [1:0] lev_q;
	logic [31:0] cur_q;
	logic [31:0] lvl_q [qti_pkg::AXES];
	logic [50:0] prod_s1;
	logic [31:0] a0_s1;
	logic m_valid_q;
	logic [31:0] m_data_q;
	logic m_flag_q;

	logic in_xfer;
	qti_pkg::op_t op;
	logic [11:0] w_index;
	logic [31:0] w_value;
	logic [CW-1:0] n_pts, last;
	logic [31:0] x, gd, tv;
	logic grd_we, tbl_we;
	logic [qti_pkg::GRID_AW-1:0] grd_waddr, grd_raddr;
	logic [qti_pkg::TBL_AW-1:0] tbl_raddr;
	logic signed [31:0] xs, g0s, gls, los, his;
	logic signed [32:0] num, step;
	logic [31:0] lo_m, hi_m;
	logic [IW-1:0] c_m;
	logic eq0, eql, outside;
	qti_pkg::div_req_t dreq;
	qti_pkg::div_rsp_t drsp;
	logic [IW-1:0] ca [qti_pkg::AXES];
	logic signed [32:0] diff;
	logic signed [34:0] sum;
	logic finish;
	logic out_free;

	assign in_xfer = s_tvalid && s_tready;
	assign op = qti_pkg::op_t'(s_tuser);
	assign w_index = s_tdata[13:2];
	assign w_value = s_tdata[45:14];
	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		priority if (pts_q[axis_q] < qti_pkg::MIN_POINTS) begin
			n_pts = qti_pkg::MIN_POINTS;
		end else if (pts_q[axis_q] > qti_pkg::MAX_POINTS) begin
			n_pts = qti_pkg::MAX_POINTS;
		end else begin
			n_pts = pts_q[axis_q];
		end
	end
	assign last = n_pts - CW'(1);
	assign x = coord_q[axis_q];

	assign grd_we = in_xfer && (op == qti_pkg::OP_GRID)
		&& (w_index < 12'(qti_pkg::POINTS));
	assign grd_waddr = {s_tdata[1:0], w_index[IW-1:0]};
	assign grd_raddr = {axis_q, ptr_q[IW-1:0]};
	assign tbl_we = in_xfer && (op == qti_pkg::OP_TABLE);

	qti_ram #(.AW(qti_pkg::GRID_AW), .DW(qti_pkg::VAL_W)) u_grid (
		.clk   (clk),
		.we    (grd_we),
		.waddr (grd_waddr),
		.wdata (w_value),
		.raddr (grd_raddr),
		.rdata (gd)
	);

	always_comb begin
		for (int k = 0; k < qti_pkg::AXES; k++) begin
			ca[k] = cell_q[k] + IW'(corner_q[k]);
		end
	end
	assign tbl_raddr = {ca[0], ca[1], ca[2], ca[3]};

	qti_ram #(.AW(qti_pkg::TBL_AW), .DW(qti_pkg::VAL_W)) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (w_index[qti_pkg::TBL_AW-1:0]),
		.wdata (w_value),
		.raddr (tbl_raddr),
		.rdata (tv)
	);

	assign xs = x;
	assign g0s = g0_q;
	assign gls = glast_q;
	assign eq0 = (x == g0_q);
	assign eql = (x == glast_q);
	assign outside = (xs < g0s) || (xs > gls);
	assign lo_m = found_q ? lo_q : g0_q;
	assign hi_m = found_q ? hi_q : g1_q;
	assign c_m = found_q ? fc_q : '0;
	assign los = lo_m;
	assign his = hi_m;
	assign num = 33'(xs) - 33'(los);
	assign step = 33'(his) - 33'(los);

	assign dreq.start = (state_q == ST_DECIDE) && !eq0 && !eql && !outside
		&& (num > 33'sd0) && (step > 33'sd0) && (num < step);
	assign dreq.num = num[31:0];
	assign dreq.step = step[31:0];

	qti_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign diff = 33'($signed(cur_q)) - 33'($signed(lvl_q[lev_q]));
	assign sum = 35'($signed(a0_s1)) + $signed(prod_s1[50:16]);
	assign out_free = !m_valid_q || m_tready;
	assign finish = (state_q == ST_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int k = 0; k < qti_pkg::AXES; k++) begin
				pts_q[k] <= qti_pkg::MAX_POINTS;
			end
			axis_q <= '0;
			ptr_q <= '0;
			didx_q <= '0;
			dv_q <= 1'b0;
			found_q <= 1'b0;
			oor_q <= 1'b0;
			corner_q <= '0;
			lev_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				pts_q[cfg_addr] <= cfg_data;
			end
			if (finish) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && (op == qti_pkg::OP_QUERY)) begin
						state_q <= ST_SCAN;
						axis_q <= '0;
						ptr_q <= '0;
						dv_q <= 1'b0;
						found_q <= 1'b0;
						oor_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (ptr_q <= last) begin
						ptr_q <= ptr_q + CW'(1);
						dv_q <= 1'b1;
						didx_q <= ptr_q;
					end else begin
						dv_q <= 1'b0;
					end
					if (dv_q) begin
						if ((didx_q != '0) && !found_q && ($signed(prev_q) <= xs)
							&& (xs < $signed(gd))) begin
							found_q <= 1'b1;
						end
						if (didx_q == last) begin
							state_q <= ST_DECIDE;
							dv_q <= 1'b0;
						end
					end
				end
				ST_DECIDE: begin
					ptr_q <= '0;
					found_q <= 1'b0;
					if (dreq.start) begin
						state_q <= ST_DIV;
					end else if (outside && !eq0 && !eql) begin
						oor_q <= 1'b1;
						state_q <= ST_DONE;
					end else if (axis_q == 2'd3) begin
						corner_q <= '0;
						state_q <= ST_FETCH;
					end else begin
						axis_q <= axis_q + 2'd1;
						state_q <= ST_SCAN;
					end
				end
				ST_DIV: begin
					if (drsp.done) begin
						if (axis_q == 2'd3) begin
							corner_q <= '0;
							state_q <= ST_FETCH;
						end else begin
							axis_q <= axis_q + 2'd1;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_FETCH: begin
					state_q <= ST_CAPT;
				end
				ST_CAPT: begin
					lev_q <= '0;
					state_q <= ST_CHAIN;
				end
				ST_CHAIN: begin
					if (!corner_q[lev_q]) begin
						corner_q <= corner_q + 4'd1;
						state_q <= ST_FETCH;
					end else begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (lev_q == 2'd3) begin
						state_q <= ST_DONE;
					end else begin
						lev_q <= lev_q + 2'd1;
						state_q <= ST_CHAIN;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && (op == qti_pkg::OP_QUERY)) begin
			coord_q[0] <= s_tdata[77:46];
			coord_q[1] <= s_tdata[109:78];
			coord_q[2] <= s_tdata[141:110];
			coord_q[3] <= s_tdata[173:142];
		end
		if ((state_q == ST_SCAN) && dv_q) begin
			prev_q <= gd;
			if (didx_q == '0) begin
				g0_q <= gd;
			end
			if (didx_q == CW'(1)) begin
				g1_q <= gd;
			end
			if (didx_q == last) begin
				glast_q <= gd;
			end
			if ((didx_q != '0) && !found_q && ($signed(prev_q) <= xs)
				&& (xs < $signed(gd))) begin
				fc_q <= IW'(didx_q - CW'(1));
				lo_q <= prev_q;
				hi_q <= gd;
			end
		end
		if (state_q == ST_DECIDE) begin
			priority if (eq0) begin
				cell_q[axis_q] <= '0;
				wt_q[axis_q] <= '0;
			end else if (eql) begin
				cell_q[axis_q] <= IW'(last - CW'(1));
				wt_q[axis_q] <= qti_pkg::ONE_WEIGHT;
			end else begin
				cell_q[axis_q] <= c_m;
				if ((num <= 33'sd0) || (step <= 33'sd0)) begin
					wt_q[axis_q] <= '0;
				end else if (num >= step) begin
					wt_q[axis_q] <= qti_pkg::ONE_WEIGHT;
				end else begin
					wt_q[axis_q] <= '0;
				end
			end
		end
		if ((state_q == ST_DIV) && drsp.done) begin
			wt_q[axis_q] <= {1'b0, drsp.quo};
		end
		if (state_q == ST_CAPT) begin
			cur_q <= tv;
		end
		if (state_q == ST_CHAIN) begin
			if (!corner_q[lev_q]) begin
				lvl_q[lev_q] <= cur_q;
			end else begin
				prod_s1 <= 51'($signed({1'b0, wt_q[lev_q]}) * diff);
				a0_s1 <= lvl_q[lev_q];
			end
		end
		if (state_q == ST_ADD) begin
			cur_q <= sum[31:0];
		end
		if (finish) begin
			m_data_q <= oor_q ? 32'd0 : cur_q;
			m_flag_q <= oor_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;
	assign m_tuser = m_flag_q;
endmodule

[sv/qti_ram.sv]
// single port write, single port read synchronous ram with registered read
module qti_ram #(
	parameter int unsigned AW = 5,
	parameter int unsigned DW = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem_q [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[sv/qti_divider.sv]
// restoring divider for the cell weight, one quotient bit per cycle
module qti_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  qti_pkg::div_req_t req,
	output qti_pkg::div_rsp_t rsp
);
	logic [32:0] rem_q;
	logic [31:0] step_q;
	logic [15:0] quo_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] r2;
	logic        ge;

	assign r2 = {rem_q[31:0], 1'b0};
	assign ge = r2 >= {1'b0, step_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {1'b0, req.num};
			step_q <= req.step;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (r2 - {1'b0, step_q}) : r2;
			quo_q <= {quo_q[14:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;
endmodule

[sv/qti_checker.sv]
// port level checks of the quadrilinear table interpolator
module qti_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 32'd0)
		else $error("out of range result not zero");

	a_write_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser != qti_pkg::OP_QUERY) |=> s_tready)
		else $error("write transfer stalled input");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == qti_pkg::OP_QUERY) |=> !s_tready)
		else $error("query did not occupy block");
endmodule

bind quadrilinear_table_interpolator_unit qti_checker u_qti_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[tb/tb_quadrilinear_table_interpolator_unit.sv]
// self-checking testbench of the quadrilinear table interpolator unit
module tb_quadrilinear_table_interpolator_unit;
	import qti_pkg::*;

	typedef struct {
		op_t                op;
		logic [1:0]         axis;
		logic [11:0]        idx;
		logic [31:0]        val;
		logic [3:0][31:0]   crd;
		bit                 typed;
		logic [31:0]        exp_val;
		logic               exp_oor;
	} item_t;

	typedef struct {
		logic [31:0] value;
		logic        oor;
	} interp_res_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [175:0] s_tdata = '0;
	logic [1:0]   s_tuser = OP_NONE;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [31:0]  m_tdata;
	logic         m_tuser;
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_addr = '0;
	logic [3:0]   cfg_data = '0;

	logic signed [31:0] grid_m [AXES][POINTS];
	logic signed [31:0] tbl_m [POINTS**4];
	bit                 tbl_written [POINTS**4];
	int                 count_m [AXES];
	interp_res_t        result_q [$];
	int                 errors = 0;
	bit                 quiet = 1'b0;
	int                 hold_req = 0;
	int                 hold_seen = 0;
	int                 hold_cnt = 0;
	item_t              rows [$];

	quadrilinear_table_interpolator_unit i_dut (.*);

	always #5 clk = ~clk;

	initial begin
		#50_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic int eff_count(int ax);
		int n;
		n = count_m[ax];
		if (n < 2) n = 2;
		if (n > POINTS) n = POINTS;
		return n;
	endfunction

	function automatic bit find_cell(int ax, longint x, output int cidx, output longint wt);
		int last;
		int c;
		longint num;
		longint stp;
		last = eff_count(ax) - 1;
		c = 0;
		cidx = 0;
		wt = 0;
		if (x == grid_m[ax][0]) return 1'b1;
		if (x == grid_m[ax][last]) begin
			cidx = last - 1;
			wt = 65536;
			return 1'b1;
		end
		if (x < grid_m[ax][0] || x > grid_m[ax][last]) return 1'b0;
		for (int i = 0; i < last; i++) begin
			if (x >= grid_m[ax][i] && x < grid_m[ax][i+1]) begin
				c = i;
				break;
			end
		end
		num = x - grid_m[ax][c];
		stp = longint'(grid_m[ax][c+1]) - grid_m[ax][c];
		if (num <= 0 || stp <= 0) wt = 0;
		else if (num >= stp) wt = 65536;
		else wt = (num <<< 16) / stp;
		cidx = c;
		return 1'b1;
	endfunction

	function automatic interp_res_t interpolate(logic [3:0][31:0] crd);
		interp_res_t r;
		int cidx [4];
		longint wt [4];
		longint v [16];
		int addr;
		bit in_grid;
		in_grid = 1'b1;
		for (int k = 0; k < 4; k++)
			if (!find_cell(k, longint'($signed(crd[k])), cidx[k], wt[k])) in_grid = 1'b0;
		if (!in_grid) begin
			r.value = '0;
			r.oor = 1'b1;
			return r;
		end
		for (int b = 0; b < 16; b++) begin
			addr = 0;
			for (int k = 0; k < 4; k++) addr = addr * POINTS + cidx[k] + ((b >> k) & 1);
			v[b] = tbl_m[addr];
		end
		for (int k = 0; k < 4; k++)
			for (int j = 0; j < (8 >> k); j++)
				v[j] = v[2*j] + ((wt[k] * (v[2*j+1] - v[2*j])) >>> 16);
		r.value = v[0][31:0];
		r.oor = 1'b0;
		return r;
	endfunction

	function automatic item_t mk(op_t op, logic [1:0] ax, logic [11:0] idx, logic [31:0] val,
			logic [31:0] c0, logic [31:0] c1, logic [31:0] c2, logic [31:0] c3,
			bit typed = 1'b0, logic [31:0] ev = '0, logic eo = 1'b0);
		item_t it;
		it.op = op;
		it.axis = ax;
		it.idx = idx;
		it.val = val;
		it.crd = {c3, c2, c1, c0};
		it.typed = typed;
		it.exp_val = ev;
		it.exp_oor = eo;
		return it;
	endfunction

	task automatic send(item_t it);
		interp_res_t r;
		while (!quiet && $urandom_range(99) < 17) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.op;
		s_tdata <= {2'b00, it.crd, it.val, it.idx, it.axis};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		case (it.op)
			OP_GRID: if (it.idx < POINTS) grid_m[it.axis][it.idx] = it.val;
			OP_TABLE: begin
				tbl_m[it.idx] = it.val;
				tbl_written[it.idx] = 1'b1;
			end
			OP_QUERY: begin
				if (it.typed) begin
					r.value = it.exp_val;
					r.oor = it.exp_oor;
				end else begin
					r = interpolate(it.crd);
				end
				result_q.push_back(r);
			end
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (result_q.size() != 0) @(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic set_counts(int c0, int c1, int c2, int c3);
		int cs [4];
		cs = '{c0, c1, c2, c3};
		for (int k = 0; k < 4; k++) begin
			cfg_we <= 1'b1;
			cfg_addr <= k[1:0];
			cfg_data <= cs[k][3:0];
			count_m[k] = cs[k] & 15;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic fill_box();
		int n [4];
		int addr;
		for (int k = 0; k < 4; k++) n[k] = eff_count(k);
		for (int a = 0; a < n[0]; a++)
			for (int b = 0; b < n[1]; b++)
				for (int c = 0; c < n[2]; c++)
					for (int d = 0; d < n[3]; d++) begin
						addr = ((a * POINTS + b) * POINTS + c) * POINTS + d;
						if (!tbl_written[addr])
							send(mk(OP_TABLE, 2'd0, addr[11:0], $urandom(), 0, 0, 0, 0));
					end
	endtask

	task automatic new_grids();
		longint g;
		for (int k = 0; k < 4; k++) begin
			g = -longint'($urandom_range(32'h4000_0000));
			for (int i = 0; i < eff_count(k); i++) begin
				send(mk(OP_GRID, k[1:0], i[11:0], g[31:0], 0, 0, 0, 0));
				case ($urandom_range(3))
					0: g += 1;
					1: g += $urandom_range(32'h0100_0000, 1);
					default: g += $urandom_range(32'h0004_0000, 1);
				endcase
			end
		end
	endtask

	function automatic logic [31:0] pick_coord(int ax);
		int last;
		longint lo;
		longint hi;
		int r;
		last = eff_count(ax) - 1;
		lo = grid_m[ax][0];
		hi = grid_m[ax][last];
		if (hi < lo) begin
			lo = grid_m[ax][last];
			hi = grid_m[ax][0];
		end
		r = $urandom_range(39);
		if (r < 4) return grid_m[ax][$urandom_range(last)];
		if (r == 4) return 32'(lo - 1 - $urandom_range(1000));
		if (r == 5) return 32'(hi + 1 + $urandom_range(1000));
		if (r == 6) return $urandom();
		return 32'(lo + longint'($urandom()) % (hi - lo + 1));
	endfunction

	task automatic random_item();
		int r;
		logic [3:0][31:0] c;
		r = $urandom_range(99);
		for (int k = 0; k < 4; k++) c[k] = pick_coord(k);
		if (r < 76) begin
			send(mk(OP_QUERY, 2'($urandom()), 12'($urandom()), $urandom(), c[0], c[1], c[2], c[3]));
		end else if (r < 81) begin
			send(mk(OP_QUERY, 2'($urandom()), 12'($urandom()), $urandom(),
				$urandom(), $urandom(), $urandom(), $urandom()));
		end else if (r < 91) begin
			send(mk(OP_TABLE, 2'($urandom()), 12'($urandom()), $urandom(), $urandom(),
				$urandom(), $urandom(), $urandom()));
		end else if (r < 95) begin
			send(mk(OP_GRID, 2'($urandom()), 12'($urandom_range(15)),
				32'(longint'(grid_m[0][0]) + $urandom_range(32'h0010_0000)), 0, 0, 0, 0));
		end else if (r < 97) begin
			send(mk(OP_GRID, 2'($urandom()), 12'($urandom()), $urandom(), 0, 0, 0, 0));
		end else begin
			send(mk(OP_NONE, 2'($urandom()), 12'($urandom()), $urandom(), $urandom(),
				$urandom(), $urandom(), $urandom()));
		end
	endtask

	// result check and receiver stall
	always @(posedge clk) begin
		interp_res_t e;
		if (m_tvalid && m_tready) begin
			if (result_q.size() == 0) begin
				$display("%0t: unexpected transfer, actual %h oor %b", $time, m_tdata, m_tuser);
				errors++;
			end else begin
				e = result_q.pop_front();
				if (m_tdata !== e.value) begin
					$display("%0t: interpolated expected %h actual %h", $time, e.value, m_tdata);
					errors++;
				end
				if (m_tuser !== e.oor) begin
					$display("%0t: out_of_range expected %b actual %b", $time, e.oor, m_tuser);
					errors++;
				end
			end
		end
		if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_cnt <= 600;
			m_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet || ($urandom_range(99) >= 17);
		end
	end

	initial begin
		int phases [8][4];
		arst_n <= 1'b0;
		phases = '{'{2, 2, 2, 2}, '{8, 2, 2, 2}, '{2, 8, 2, 2}, '{2, 2, 8, 2},
			'{2, 2, 2, 8}, '{3, 2, 2, 3}, '{0, 1, 15, 3}, '{3, 3, 2, 2}};
		for (int k = 0; k < 4; k++) count_m[k] = 8;
		for (int a = 0; a < POINTS**4; a++) tbl_written[a] = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on unit grids
		set_counts(2, 2, 2, 2);
		for (int k = 0; k < 4; k++)
			for (int i = 0; i < POINTS; i++)
				send(mk(OP_GRID, k[1:0], i[11:0], i * 32'h1_0000, 0, 0, 0, 0));
		send(mk(OP_TABLE, 2'd0, 12'd0, 32'h0005_0000, 0, 0, 0, 0));
		fill_box();
		rows.push_back(mk(OP_QUERY, 2'd0, 12'd0, 0, 0, 0, 0, 0, 1, 32'h0005_0000, 0));
		rows.push_back(mk(OP_QUERY, 2'd3, 12'hFFF, '1, 32'h8000_0000, 0, 0, 0, 1, 0, 1));
		rows.push_back(mk(OP_QUERY, 2'd0, 12'd0, 0, 0, 0, 0, 32'h7FFF_FFFF, 1, 0, 1));
		rows.push_back(mk(OP_QUERY, 2'd0, 12'd0, 0, 0, 32'hFFFF_FFFF, 0, 0, 1, 0, 1));
		rows.push_back(mk(OP_QUERY, 2'd0, 12'd0, 0, 32'h1_0000, 32'h1_0000, 32'h1_0000,
			32'h1_0000));
		rows.push_back(mk(OP_QUERY, 2'd0, 12'd0, 0, 32'h8000, 32'h8000, 32'h8000, 32'h8000));
		rows.push_back(mk(OP_QUERY, 2'd0, 12'd0, 0, 32'hFFFF, 32'h1, 32'h7FFF, 32'hFFFF));
		rows.push_back(mk(OP_NONE, 2'd3, 12'hFFF, '1, '1, '1, '1, '1));
		rows.push_back(mk(OP_GRID, 2'd0, 12'd8, 32'h1234_5678, 0, 0, 0, 0));
		rows.push_back(mk(OP_GRID, 2'd3, 12'hFFF, 32'h8000_0000, 0, 0, 0, 0));
		rows.push_back(mk(OP_QUERY, 2'd0, 12'd0, 0, 0, 0, 0, 0, 1, 32'h0005_0000, 0));
		rows.push_back(mk(OP_TABLE, 2'd0, 12'd0, 32'h7FFF_FFFF, 0, 0, 0, 0));
		rows.push_back(mk(OP_QUERY, 2'd0, 12'd0, 0, 0, 0, 0, 0, 1, 32'h7FFF_FFFF, 0));
		rows.push_back(mk(OP_TABLE, 2'd0, 12'd0, 32'h8000_0000, 0, 0, 0, 0));
		rows.push_back(mk(OP_TABLE, 2'd0, 12'd1, 32'h7FFF_FFFF, 0, 0, 0, 0));
		rows.push_back(mk(OP_QUERY, 2'd0, 12'd0, 0, 0, 0, 0, 32'h8000));
		rows.push_back(mk(OP_QUERY, 2'd0, 12'd0, 0, 0, 0, 0, 32'hFFFF));
		rows.push_back(mk(OP_GRID, 2'd1, 12'd1, 32'h0, 0, 0, 0, 0));
		rows.push_back(mk(OP_QUERY, 2'd0, 12'd0, 0, 32'h4000, 0, 32'h4000, 32'h4000));
		rows.push_back(mk(OP_QUERY, 2'd0, 12'd0, 0, 0, 32'h4000, 0, 0, 1, 0, 1));
		rows.push_back(mk(OP_GRID, 2'd1, 12'd1, 32'h1_0000, 0, 0, 0, 0));
		rows.push_back(mk(OP_QUERY, 2'd0, 12'd0, 0, 32'h3000, 32'hC000, 32'h1, 32'hFFFE));
		foreach (rows[i]) send(rows[i]);

		// random phases through several point counts
		for (int p = 0; p < 8; p++) begin
			wait_idle();
			set_counts(phases[p][0], phases[p][1], phases[p][2], phases[p][3]);
			new_grids();
			fill_box();
			quiet = (p == 3);
			if (p == 1) hold_req++;
			for (int n = 0; n < 20; n++) begin
				if (p == 2 && n == 10) begin
					s_tvalid <= 1'b0;
					@(posedge clk);
					while (result_q.size() != 0) @(posedge clk);
				end
				random_item();
			end
			quiet = 1'b0;
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (result_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
